// File: rtl/b32dec_pkg.sv
// Shared types and constants for the base32 text decoder.
`default_nettype none

package b32dec_pkg;

	// Command codes of an input item
	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// Result kind codes
	localparam logic [1:0] KIND_DATA     = 2'd0;
	localparam logic [1:0] KIND_DONE     = 2'd1;
	localparam logic [1:0] KIND_BADSYM   = 2'd2;
	localparam logic [1:0] KIND_OVERFLOW = 2'd3;

	// Configuration register indexes
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [15:0] CAPACITY_RESET = 16'hffff;

	// One input item
	typedef struct packed {
		logic       command;
		logic [7:0] symbol;
	} in_item_t;

	// One result item
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] byte_count;
		logic        last;
	} out_item_t;

	// Per-text decoder state
	typedef struct packed {
		logic [6:0]  leftover_bits;
		logic [2:0]  leftover_count;
		logic [15:0] emitted_count;
		logic        error_latched;
		logic [1:0]  error_kind;
	} dec_state_t;

endpackage

`default_nettype wire

// File: rtl/b32dec_step.sv
// Combinational step of the decoder: classify one character or handle an end command, and update the state.
`default_nettype none

module b32dec_step (
	input  wire  b32dec_pkg::in_item_t   item,
	input  wire  b32dec_pkg::dec_state_t cur,
	input  wire  logic [15:0]            capacity,
	output b32dec_pkg::dec_state_t       nxt,
	output logic                         has_result,
	output b32dec_pkg::out_item_t        result
);

	logic       sym_skip;
	logic       sym_bad;
	logic [4:0] sym_val;
	logic [3:0] cnt;
	logic [2:0] rem;
	logic [11:0] acc;
	logic [11:0] shifted;
	logic [6:0] keep_mask;

	// Character classification
	always_comb begin
		sym_skip = 1'b0;
		sym_bad  = 1'b0;
		sym_val  = 5'd0;
		case (item.symbol) inside
			8'h20, 8'h09, 8'h0d, 8'h0a, 8'h2d, 8'h3d: sym_skip = 1'b1;
			[8'h41:8'h5a]: sym_val = 5'(item.symbol - 8'h41);
			[8'h61:8'h7a]: sym_val = 5'(item.symbol - 8'h61);
			[8'h32:8'h37]: sym_val = 5'(item.symbol - 8'h32 + 8'd26);
			default: sym_bad = 1'b1;
		endcase
	end

	// Accumulator: new 5 bits enter at the bottom
	assign acc       = {cur.leftover_bits, sym_val};
	assign cnt       = {1'b0, cur.leftover_count} + 4'd5;
	assign rem       = 3'(cnt - 4'd8);
	assign shifted   = acc >> rem;
	assign keep_mask = 7'((8'd1 << rem) - 8'd1);

	// Next state and result
	always_comb begin
		nxt               = cur;
		has_result        = 1'b0;
		result.kind       = b32dec_pkg::KIND_DATA;
		result.data_byte  = 8'd0;
		result.byte_count = cur.emitted_count;
		result.last       = 1'b1;
		if (item.command == b32dec_pkg::CMD_END) begin
			has_result  = 1'b1;
			result.kind = cur.error_latched ? cur.error_kind : b32dec_pkg::KIND_DONE;
			nxt         = '0;
		end else if (!cur.error_latched && !sym_skip) begin
			if (sym_bad) begin
				has_result        = 1'b1;
				result.kind       = b32dec_pkg::KIND_BADSYM;
				nxt.error_latched = 1'b1;
				nxt.error_kind    = b32dec_pkg::KIND_BADSYM;
			end else if (cnt < 4'd8) begin
				nxt.leftover_bits  = acc[6:0];
				nxt.leftover_count = cnt[2:0];
			end else if (cur.emitted_count >= capacity) begin
				has_result        = 1'b1;
				result.kind       = b32dec_pkg::KIND_OVERFLOW;
				nxt.error_latched = 1'b1;
				nxt.error_kind    = b32dec_pkg::KIND_OVERFLOW;
			end else begin
				has_result         = 1'b1;
				result.kind        = b32dec_pkg::KIND_DATA;
				result.data_byte   = shifted[7:0];
				result.byte_count  = cur.emitted_count + 16'd1;
				result.last        = 1'b0;
				nxt.leftover_bits  = acc[6:0] & keep_mask;
				nxt.leftover_count = rem;
				nxt.emitted_count  = cur.emitted_count + 16'd1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/base32_text_decoder.sv
// Base32 text decoder top level: input stage, decode step and result register.
//
// Usage: one character (or an end command) per transfer on the in_* channel;
// decoded bytes, the final done status or an error come out on the out_*
// channel, at most one result per input item. Skipped characters, partial
// symbols and characters after an error give no result.
// The capacity register (APB, address 0) bounds the byte count of one text;
// write it only while the decoder is idle.
// An accepted item is held in the input stage, decoded against the per-text state
// and registered in the result register once that register can take a result.
// Throughput: one item per cycle unless the receiver stalls; the decode step is a
// single short classify-shift-compare path from input stage to result register.
// When the receiver stalls, the result register holds, the input stage fills
// and in_ready drops; no item is lost or repeated.
// Reset: both stages empty, per-text state cleared, capacity = 65535.
// The end command returns done (or the latched error) with the byte count and
// clears the per-text state, dropping leftover bits.
`default_nettype none

module base32_text_decoder (
	input  wire  logic                  clk,
	input  wire  logic                  arst_n,
	input  wire  logic                  in_valid,
	output logic                        in_ready,
	input  wire  b32dec_pkg::in_item_t  in_item,
	output logic                        out_valid,
	input  wire  logic                  out_ready,
	output b32dec_pkg::out_item_t       out_item,
	input  wire  logic                  psel,
	input  wire  logic                  penable,
	input  wire  logic                  pwrite,
	input  wire  logic [2:0]            paddr,
	input  wire  logic [31:0]           pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic                   item_valid_s1;
	b32dec_pkg::in_item_t   item_s1;
	b32dec_pkg::dec_state_t state_q;
	b32dec_pkg::dec_state_t state_nxt;
	logic [15:0]            capacity_q;
	logic                   res_valid_s2;
	b32dec_pkg::out_item_t  res_s2;
	logic                   step_has_res;
	b32dec_pkg::out_item_t  step_res;
	logic                   out_free;
	logic                   advance;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == b32dec_pkg::REG_CAPACITY) ? {16'd0, capacity_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= b32dec_pkg::CAPACITY_RESET;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == b32dec_pkg::REG_CAPACITY) begin
			capacity_q <= pwdata[15:0];
		end
	end

	// Handshake: stage 1 moves on when the result register can take a result
	assign out_free = !res_valid_s2 || out_ready;
	assign advance  = item_valid_s1 && out_free;
	assign in_ready = !item_valid_s1 || out_free;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// Decode step
	b32dec_step u_step (
		.item       (item_s1),
		.cur        (state_q),
		.capacity   (capacity_q),
		.nxt        (state_nxt),
		.has_result (step_has_res),
		.result     (step_res)
	);

	// Per-text state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (out_free) begin
			res_valid_s2 <= advance && step_has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_has_res) begin
			res_s2 <= step_res;
		end
	end

	assign out_valid = res_valid_s2;
	assign out_item  = res_s2;

	// Checks
	a_data_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == b32dec_pkg::KIND_DATA |-> !out_item.last &&
		out_item.byte_count != 16'd0)
		else $error("data result marked last or with zero count");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind != b32dec_pkg::KIND_DATA |->
		out_item.last && out_item.data_byte == 8'd0)
		else $error("status result with data or without last");

	a_error_latches: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_has_res && item_s1.command == b32dec_pkg::CMD_CHAR &&
		step_res.kind != b32dec_pkg::KIND_DATA |=> state_q.error_latched)
		else $error("error result without latched error");

	a_error_kind: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.error_latched |-> state_q.error_kind == b32dec_pkg::KIND_BADSYM ||
		state_q.error_kind == b32dec_pkg::KIND_OVERFLOW)
		else $error("latched error kind is not an error code");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.command == b32dec_pkg::CMD_END |=>
		state_q.emitted_count == 16'd0 && !state_q.error_latched &&
		state_q.leftover_count == 3'd0)
		else $error("end command did not clear the text state");

endmodule

`default_nettype wire
